// ===== sv/rxff_pkg.sv =====
package rxff_pkg;

   localparam int DEPTH = 8;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int THR_W = 3;
   localparam int OCC_W = 3;
   localparam int CMP_W = (PTR_W > THR_W) ? PTR_W : THR_W;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 3;

   localparam logic [1:0] ACT_RECEIVE = 2'd0;
   localparam logic [1:0] ACT_READ    = 2'd1;
   localparam logic [1:0] ACT_START   = 2'd2;
   localparam logic [1:0] ACT_STOP    = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_FLOW_ENABLE     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_THRESHOLD = CSR_IDX_W'(1);

   localparam logic [7:0] XON_CHAR  = 8'h11;
   localparam logic [7:0] XOFF_CHAR = 8'h13;

   localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(2);

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] rx_byte;
      logic       overrun_error;
      logic       framing_error;
   } rxff_req_type;

   typedef struct packed {
      logic             read_valid;
      logic [7:0]       read_byte;
      logic             flow_send;
      logic [7:0]       flow_byte;
      logic             dropped_oldest;
      logic             error_dropped;
      logic [OCC_W-1:0] occupancy;
   } rxff_rsp_type;

   typedef struct packed {
      logic             flow_enable;
      logic [THR_W-1:0] spare_threshold;
   } rxff_cfg_type;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   function automatic logic [PTR_W-1:0] fill_level(input logic [PTR_W-1:0] wp,
                                                   input logic [PTR_W-1:0] rp);
      logic [PTR_W:0] diff;
      diff = {1'b0, wp} - {1'b0, rp};
      if (wp < rp) begin
         diff = diff + (PTR_W + 1)'(DEPTH);
      end
      return diff[PTR_W-1:0];
   endfunction

endpackage

// ===== sv/rxff_core.sv =====
module rxff_core
   import rxff_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  rxff_req_type item,
   input  rxff_cfg_type cfg,
   output rxff_rsp_type result
);

   logic [7:0]       store_ff [DEPTH];
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [PTR_W-1:0] rp_ff, rp_in;
   logic             sender_ff, sender_in;
   logic             store_we;

   logic [PTR_W-1:0] wp_adv;
   logic [PTR_W-1:0] rp_adv;
   logic [PTR_W-1:0] free_space;
   logic             has_error;
   logic             not_empty;

   assign wp_adv     = ptr_next(wp_ff);
   assign rp_adv     = ptr_next(rp_ff);
   assign free_space = PTR_W'(DEPTH - 1) - fill_level(wp_adv, rp_ff);
   assign has_error  = item.overrun_error || item.framing_error;
   assign not_empty  = (wp_ff != rp_ff);

   always_comb begin
      wp_in     = wp_ff;
      rp_in     = rp_ff;
      sender_in = sender_ff;
      store_we  = 1'b0;
      result    = '0;
      case (item.action)
         ACT_RECEIVE: begin
            if (has_error) begin
               result.error_dropped = 1'b1;
            end else begin
               store_we = 1'b1;
               wp_in    = wp_adv;
               if (cfg.flow_enable && sender_ff &&
                   (CMP_W'(free_space) <= CMP_W'(cfg.spare_threshold))) begin
                  result.flow_send = 1'b1;
                  result.flow_byte = XOFF_CHAR;
                  sender_in        = 1'b0;
               end
               if (wp_adv == rp_ff) begin
                  rp_in                 = rp_adv;
                  result.dropped_oldest = 1'b1;
               end
            end
         end
         ACT_READ: begin
            if (not_empty) begin
               result.read_valid = 1'b1;
               result.read_byte  = store_ff[rp_ff];
               rp_in             = rp_adv;
               if (cfg.flow_enable && !sender_ff && (rp_adv == wp_ff)) begin
                  result.flow_send = 1'b1;
                  result.flow_byte = XON_CHAR;
                  sender_in        = 1'b1;
               end
            end
         end
         ACT_START: begin
            wp_in     = '0;
            rp_in     = '0;
            sender_in = 1'b1;
            if (cfg.flow_enable) begin
               result.flow_send = 1'b1;
               result.flow_byte = XON_CHAR;
            end
         end
         ACT_STOP: begin
            if (cfg.flow_enable && sender_ff) begin
               result.flow_send = 1'b1;
               result.flow_byte = XOFF_CHAR;
               sender_in        = 1'b0;
            end
         end
         default: begin
            result = '0;
         end
      endcase
      result.occupancy = OCC_W'(fill_level(wp_in, rp_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff     <= '0;
         rp_ff     <= '0;
         sender_ff <= 1'b1;
      end else if (step) begin
         wp_ff     <= wp_in;
         rp_ff     <= rp_in;
         sender_ff <= sender_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && store_we) begin
         store_ff[wp_ff] <= item.rx_byte;
      end
   end

endmodule

// ===== sv/rx_fifo_xon_xoff.sv =====
// UART receive ring buffer with XON/XOFF software flow control.
// Request channel (req_valid/req_ready/req_data) carries one command per
// transaction: received byte, read, start or stop. The response channel
// (rsp_valid/rsp_ready/rsp_data) returns exactly one result per command:
// the byte read, the flow control character to transmit, drop flags and
// the buffer occupancy after the command.
// Configuration writes use csr_valid/csr_ready/csr_index/csr_data; index 0
// is flow_enable, index 1 is spare_threshold. csr_ready is always high.
// A command accepted into the input register is processed as it moves
// into the response register, where its response becomes valid.
// Throughput: one command per cycle while the receiver takes responses;
// the input register feeds single-pass logic into the response register,
// all buffer state updating as the command moves into the response register.
// When the receiver stalls, the response register holds and one more
// command waits in the input register; req_ready then drops.
// Reset clears both pointers, enables the sender, sets flow_enable to 0
// and spare_threshold to 2. Buffer contents are not cleared.
module rx_fifo_xon_xoff
   import rxff_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rxff_req_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rxff_rsp_type          rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic         s1_valid_ff, s1_valid_in;
   rxff_req_type s1_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rxff_rsp_type rsp_data_ff;
   rxff_cfg_type cfg_ff;
   rxff_rsp_type core_result;
   logic         advance;
   logic         req_fire;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   rxff_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (s1_item_ff),
      .cfg    (cfg_ff),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= core_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flow_enable     <= 1'b0;
         cfg_ff.spare_threshold <= THRESHOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FLOW_ENABLE: begin
               cfg_ff.flow_enable <= csr_data[0];
            end
            CSR_SPARE_THRESHOLD: begin
               cfg_ff.spare_threshold <= csr_data[THR_W-1:0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // a waiting command with an empty response register moves on at once
   a_advance: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !rsp_valid_ff |=> rsp_valid_ff)
      else $error("command not moved into empty response register");

   a_flow_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.flow_send |->
         (rsp_data_ff.flow_byte == XON_CHAR) || (rsp_data_ff.flow_byte == XOFF_CHAR))
      else $error("bad flow control character");

   a_error_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.error_dropped |->
         !rsp_data_ff.flow_send && !rsp_data_ff.dropped_oldest && !rsp_data_ff.read_valid)
      else $error("errored byte changed buffer state");

   a_read_no_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.read_valid |-> !rsp_data_ff.dropped_oldest)
      else $error("read reported a dropped byte");

endmodule
